// ===== hdl/ppse_pkg.sv =====
// Package for the pulse-period speed estimator: widths, register indexes, commands.
// Used by every module of the block; depends on nothing.
`default_nettype none
package ppse_pkg;
  localparam int AvgDepth = 8;
  localparam int SlotW = $clog2(AvgDepth);
  localparam int FillW = $clog2(AvgDepth + 1);
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_K = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_SPEED = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FAST_THR = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ALPHA_FAST = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ALPHA_SLOW = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 3'd5;

  localparam logic CMD_PULSE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Divider request: 40-bit dividend over 35-bit divisor.
  typedef struct packed {
    logic        start;
    logic [39:0] dividend;
    logic [34:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [39:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/ppse_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on ppse_pkg for the request and response structs.
`default_nettype none
module ppse_divider
  import ppse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  div_req_t      req,
  output div_rsp_t      rsp
);
  logic [39:0] quo;
  logic [35:0] rem;
  logic [34:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [35:0] shifted;
  logic [36:0] trial;

  assign shifted = {rem[34:0], quo[39]};
  assign trial = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd40;
        quo <= req.dividend;
        rem <= '0;
        dvs <= req.divisor;
      end else if (busy) begin
        // Quotient bits shift in at the bottom as dividend bits leave the top.
        if (!trial[36]) begin
          rem <= trial[35:0];
          quo <= {quo[38:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[38:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rsp = {done, quo};

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt != 6'd0)
    else $error("divider count underflow");
  assert property (@(posedge clk) disable iff (rst) req.start |=> busy)
    else $error("divider did not start");
endmodule
`default_nettype wire

// ===== hdl/pulse_period_speed_estimator_unit.sv =====
// Top level of the pulse-period speed estimator: config registers, sequencer, ring.
// Depends on ppse_pkg and ppse_divider.
//
//  channel | signals                                   | direction
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data     | in (ready out)
//  in      | in_valid in_stall cmd timestamp_us         | in (stall out)
//  out     | out_valid out_stall speed_q8 updated glitch| out (stall in)
//
// A tick, a first pulse or a glitch goes from S_IDLE through S_CHECK to S_OUT before
// the next input transaction; an accepted pulse also takes two passes through the shared
// serial divider, a serial sweep of the filled part of the period ring and a filter
// multiply whose product is registered before it is applied (skipped while unprimed).
// Reset is synchronous and clears the sequencer, ring fill and filter state; the ring needs no clearing.
// While a result waits on out_stall no new item is taken.
`default_nettype none
module pulse_period_speed_estimator_unit
  import ppse_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               cmd,
  input  wire logic [31:0]        timestamp_us,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             speed_q8,
  output logic                    updated,
  output logic                    glitch
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SUM, S_DIV1, S_WAIT1, S_DIV2, S_WAIT2, S_FILT, S_APPLY, S_OUT
  } state_t;

  state_t state;
  logic [25:0] k_reg;
  logic [15:0] maxs_reg, thr_reg, af_reg, as_reg;
  logic [31:0] tmo_reg;

  logic [31:0] ring [AvgDepth];
  logic [SlotW-1:0] write_slot, rd_idx;
  logic [FillW-1:0] fill_count, sum_cnt;
  logic [31:0] last_pulse_time, period, ts_hold;
  logic have_last_pulse, filter_primed, cmd_hold;
  logic [23:0] filtered_speed;
  logic [34:0] sum;
  logic [31:0] avg;
  logic [15:0] spd;
  logic [24:0] err_mag;
  logic err_neg;
  logic [40:0] prod;
  logic [31:0] rd_data;
  logic prod_ready, publish;

  div_req_t dreq;
  div_rsp_t drsp;

  ppse_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg <= 26'd900000;
      maxs_reg <= 16'd51200;
      thr_reg <= 16'd1280;
      af_reg <= 16'd32768;
      as_reg <= 16'd6554;
      tmo_reg <= 32'd2000000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_K:          k_reg <= cfg_data[25:0];
        REG_MAX_SPEED:  maxs_reg <= cfg_data[15:0];
        REG_FAST_THR:   thr_reg <= cfg_data[15:0];
        REG_ALPHA_FAST: af_reg <= cfg_data[15:0];
        REG_ALPHA_SLOW: as_reg <= cfg_data[15:0];
        REG_TIMEOUT:    tmo_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ring memory: registered read at the sweep address.
  always_ff @(posedge clk) begin
    rd_data <= ring[rd_idx];
  end

  logic [47:0] lim_lhs;
  logic [35:0] ten_k;
  logic [33:0] k256;
  assign lim_lhs = {16'd0, period} * {32'd0, maxs_reg};
  assign ten_k = {10'd0, k_reg} * 36'd10;
  assign k256 = {k_reg, 8'd0};

  logic [24:0] target;
  logic signed [25:0] err_s;
  assign target = {1'b0, spd, 8'd0};
  assign err_s = $signed({1'b0, target}) - $signed({2'b00, filtered_speed});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      write_slot <= '0;
      fill_count <= '0;
      last_pulse_time <= '0;
      have_last_pulse <= 1'b0;
      filtered_speed <= '0;
      filter_primed <= 1'b0;
      speed_q8 <= '0;
      dreq.start <= 1'b0;
      prod_ready <= 1'b0;
      publish <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_hold <= cmd;
            ts_hold <= timestamp_us;
            period <= timestamp_us - last_pulse_time;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          updated <= 1'b0;
          glitch <= 1'b0;
          state <= S_OUT;
          if (cmd_hold == CMD_TICK) begin
            if (have_last_pulse && period > tmo_reg) begin
              write_slot <= '0;
              fill_count <= '0;
              last_pulse_time <= '0;
              have_last_pulse <= 1'b0;
              filtered_speed <= '0;
              filter_primed <= 1'b0;
              speed_q8 <= '0;
              updated <= 1'b1;
            end
          end else if (!have_last_pulse) begin
            last_pulse_time <= ts_hold;
            have_last_pulse <= 1'b1;
          end else begin
            last_pulse_time <= ts_hold;
            if (lim_lhs < {14'd0, k256} || {4'd0, period} > ten_k) begin
              glitch <= 1'b1;
            end else begin
              ring[write_slot] <= period;
              write_slot <= write_slot + 1'b1;
              if (fill_count < FillW'(AvgDepth))
                fill_count <= fill_count + 1'b1;
              rd_idx <= '0;
              sum <= '0;
              sum_cnt <= '0;
              state <= S_SUM;
            end
          end
        end
        S_SUM: begin
          // One entry per cycle; read data arrives in the cycle after its address.
          if (sum_cnt != '0)
            sum <= sum + {3'd0, rd_data};
          if (sum_cnt == fill_count) begin
            state <= S_DIV1;
          end else begin
            sum_cnt <= sum_cnt + 1'b1;
            rd_idx <= rd_idx + 1'b1;
          end
        end
        S_DIV1: begin
          dreq.start <= 1'b1;
          dreq.dividend <= {5'd0, sum};
          dreq.divisor <= {{(35-FillW){1'b0}}, fill_count};
          state <= S_WAIT1;
        end
        S_WAIT1: begin
          if (drsp.done) begin
            avg <= drsp.quotient[31:0];
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          dreq.start <= 1'b1;
          dreq.dividend <= {6'd0, k256};
          dreq.divisor <= {3'd0, avg};
          state <= S_WAIT2;
        end
        S_WAIT2: begin
          if (drsp.done) begin
            if (avg == '0 || drsp.quotient > 40'd65535)
              spd <= 16'hFFFF;
            else
              spd <= drsp.quotient[15:0];
            state <= S_FILT;
          end
        end
        S_FILT: begin
          err_neg <= err_s[25];
          err_mag <= err_s[25] ? 25'(-err_s) : err_s[24:0];
          state <= S_APPLY;
          if (!filter_primed) begin
            filtered_speed <= target[23:0];
            filter_primed <= 1'b1;
            speed_q8 <= spd;
            updated <= 1'b1;
            state <= S_OUT;
          end
        end
        S_APPLY: begin
          // err_mag fits 25 bits; alpha*mag stays within 41 bits.
          if (prod_ready) begin
            if (err_neg)
              filtered_speed <= filtered_speed - 24'((prod + 41'd65535) >> 16);
            else
              filtered_speed <= filtered_speed + 24'(prod >> 16);
            publish <= 1'b1;
            prod_ready <= 1'b0;
            state <= S_OUT;
          end else begin
            prod <= {16'd0, err_mag} *
                    {25'd0, ((err_mag > {1'b0, thr_reg, 8'd0}) ? af_reg : as_reg)};
            prod_ready <= 1'b1;
          end
        end
        S_OUT: begin
          if (publish) begin
            speed_q8 <= filtered_speed[23:8];
            updated <= 1'b1;
            publish <= 1'b0;
          end else if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk) disable iff (rst) fill_count <= FillW'(AvgDepth))
    else $error("fill count overflow");
  assert property (@(posedge clk) disable iff (rst) filter_primed |-> have_last_pulse)
    else $error("filter primed without armed pulse");
endmodule
`default_nettype wire
